>>> sv/vvfm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the voxel visible face mesher.
package vvfm_pkg;

   localparam logic       OP_WRITE   = 1'b0;
   localparam logic       OP_QUERY   = 1'b1;
   localparam logic [7:0] EMPTY_CODE = 8'hFF;

   localparam logic [1:0] CSR_SIZE_X = 2'd0;
   localparam logic [1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [1:0] CSR_SIZE_Z = 2'd2;
   localparam logic [1:0] CSR_EDGE   = 2'd3;

   // read step 0 is the voxel itself, steps 1 to 6 its neighbours in face order
   localparam logic [2:0] STEP_CENTRE = 3'd0;
   localparam logic [2:0] STEP_LAST   = 3'd6;
   localparam logic [2:0] FACE_FIRST  = 3'd0;
   localparam logic [2:0] FACE_LAST   = 3'd5;

   // corner code: bit 0 = +x half, bit 1 = +y half, bit 2 = +z half
   localparam logic [2:0] TRI_CORNERS [6][6] = '{
      '{3'd0, 3'd2, 3'd1, 3'd2, 3'd3, 3'd1},
      '{3'd4, 3'd6, 3'd0, 3'd6, 3'd2, 3'd0},
      '{3'd1, 3'd3, 3'd5, 3'd3, 3'd7, 3'd5},
      '{3'd5, 3'd7, 3'd4, 3'd7, 3'd6, 3'd4},
      '{3'd4, 3'd0, 3'd5, 3'd0, 3'd1, 3'd5},
      '{3'd2, 3'd6, 3'd3, 3'd6, 3'd7, 3'd3}
   };

   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
      logic signed [1:0] dz;
   } offset_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_DRAIN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       write;
      logic       clear_en;
      logic       rd_en;
      logic [2:0] rd_step;
      logic       load_out;
      logic [2:0] face;
      logic       tri_sel;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic       in_grid;
      logic       is_query;
      logic       centre_empty;
      logic [5:0] face_mask;
      logic       out_free;
      logic       clear_done;
   } status_type;

   function automatic offset_type step_offset(input logic [2:0] step);
      offset_type off;
      off = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
      case (step)
         3'd1:    off.dz = -2'sd1;
         3'd2:    off.dx = -2'sd1;
         3'd3:    off.dx = 2'sd1;
         3'd4:    off.dz = 2'sd1;
         3'd5:    off.dy = -2'sd1;
         3'd6:    off.dy = 2'sd1;
         default: off.dx = 2'sd0;
      endcase
      return off;
   endfunction

endpackage

>>> sv/vvfm_req_if.sv
`timescale 1ns / 1ps
// Request channel: voxel writes and face queries.
interface vvfm_req_if;
   logic              valid;
   logic              ready;
   logic              op;
   logic [3:0]        pos_x;
   logic [3:0]        pos_y;
   logic [3:0]        pos_z;
   logic signed [7:0] voxel_type;

   modport source (output valid, op, pos_x, pos_y, pos_z, voxel_type, input ready);
   modport sink   (input valid, op, pos_x, pos_y, pos_z, voxel_type, output ready);
endinterface

>>> sv/vvfm_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: one triangle per item.
interface vvfm_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        face;
   logic signed [5:0] ax;
   logic signed [5:0] ay;
   logic signed [5:0] az;
   logic signed [5:0] bx;
   logic signed [5:0] by;
   logic signed [5:0] bz;
   logic signed [5:0] cx;
   logic signed [5:0] cy;
   logic signed [5:0] cz;
   logic              last;

   modport source (output valid, face, ax, ay, az, bx, by, bz, cx, cy, cz, last,
                   input ready);
   modport sink   (input valid, face, ax, ay, az, bx, by, bz, cx, cy, cz, last,
                   output ready);
endinterface

>>> sv/voxel_visible_face_mesher.sv
`timescale 1ns / 1ps
// Voxel visible face mesher. After reset the block fills all MAX_SIDE**3
// entries (4096 by default) of the voxel store with the empty code and
// takes no request until that pass ends; CSR writes are taken throughout.
// A voxel write and a query outside the grid end after the check state. A
// query in the grid reads the voxel and its six neighbours through the single
// read port of the store, one per cycle. An empty voxel then ends; for a
// filled voxel the block walks the six faces in order and emits two triangles
// per visible face, holding while the response side stalls. Triangles leave
// through a registered output stage, one per cycle while the response side
// takes them and no hidden face lies between them, so the next request is
// taken while the final triangle still waits to be collected.
module voxel_visible_face_mesher
   import vvfm_pkg::*;
#(
   parameter int MAX_SIDE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wdata,
   vvfm_req_if.sink   req_ch,
   vvfm_rsp_if.source rsp_ch
);
   cmd_type    cmd;
   status_type status;
   logic       ready;

   vvfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   vvfm_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_op         (req_ch.op),
      .req_pos_x      (req_ch.pos_x),
      .req_pos_y      (req_ch.pos_y),
      .req_pos_z      (req_ch.pos_z),
      .req_voxel_type (req_ch.voxel_type),
      .cmd            (cmd),
      .status         (status),
      .rsp_ch         (rsp_ch)
   );

   assign req_ch.ready = ready;
endmodule

>>> sv/vvfm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module vvfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/vvfm_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences clearing, voxel writes, neighbour reads and triangle output.
module vvfm_ctrl
   import vvfm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] face_ff, face_in;
   logic       tri_ff, tri_in;
   logic [5:0] above;
   logic       is_last;

   // last triangle: second of its face and no visible face further on
   assign above   = status.face_mask >> face_ff;
   assign is_last = tri_ff && (above[5:1] == 5'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= STEP_CENTRE;
         face_ff  <= FACE_FIRST;
         tri_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         face_ff  <= face_in;
         tri_ff   <= tri_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.in_grid && status.is_query) state_in = ST_READ;
            else state_in = ST_IDLE;
         end
         ST_READ: begin
            if (step_ff == STEP_LAST) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.centre_empty) state_in = ST_IDLE;
            else state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.face_mask[face_ff]) begin
               if (face_ff == FACE_LAST) state_in = ST_IDLE;
            end else if (status.out_free && is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      face_in = face_ff;
      tri_in  = tri_ff;
      case (state_ff)
         ST_CHECK:  step_in = STEP_CENTRE;
         ST_READ:   step_in = step_ff + 3'd1;
         ST_DECIDE: begin
            face_in = FACE_FIRST;
            tri_in  = 1'b0;
         end
         ST_EMIT: begin
            if (!status.face_mask[face_ff]) begin
               face_in = face_ff + 3'd1;
            end else if (status.out_free) begin
               if (tri_ff) begin
                  face_in = face_ff + 3'd1;
                  tri_in  = 1'b0;
               end else begin
                  tri_in = 1'b1;
               end
            end
         end
         default: step_in = step_ff;
      endcase
   end

   always_comb begin
      cmd         = '0;
      req_ready   = 1'b0;
      cmd.face    = face_ff;
      cmd.tri_sel = tri_ff;
      cmd.last    = is_last;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_en = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CHECK: cmd.write = status.in_grid && !status.is_query;
         ST_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_step = step_ff;
         end
         ST_DRAIN, ST_DECIDE: cmd.rd_en = 1'b0;
         ST_EMIT: cmd.load_out = status.face_mask[face_ff] && status.out_free;
         default: cmd = '0;
      endcase
   end
endmodule

>>> sv/vvfm_datapath.sv
`timescale 1ns / 1ps
// Datapath: item and size registers, voxel store, visibility mask and triangle register.
module vvfm_datapath
   import vvfm_pkg::*;
#(
   parameter int MAX_SIDE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_wdata,
   input  logic              req_op,
   input  logic [3:0]        req_pos_x,
   input  logic [3:0]        req_pos_y,
   input  logic [3:0]        req_pos_z,
   input  logic signed [7:0] req_voxel_type,
   input  cmd_type           cmd,
   output status_type        status,
   vvfm_rsp_if.source        rsp_ch
);
   localparam int DEPTH  = MAX_SIDE * MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SIZE_W = $clog2(MAX_SIDE + 1);

   logic [4:0]        size_x_ff, size_y_ff, size_z_ff;
   logic              edge_ff;
   logic              op_ff;
   logic [3:0]        x_ff, y_ff, z_ff;
   logic [7:0]        type_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              rd_valid_ff;
   logic [2:0]        rd_step_ff;
   logic              rd_in_grid_ff;
   logic              centre_empty_ff;
   logic [5:0]        mask_ff;

   logic [SIZE_W-1:0] sx, sy, sz;
   offset_type        off;
   logic signed [7:0] nx, ny, nz;
   logic              nb_in_grid;
   logic [ADDR_W-1:0] nb_addr;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [7:0]        rd_data;
   logic              rd_empty;
   logic [5:0]        mx [2], my [2], mz [2];
   logic [5:0]        corner_x [3], corner_y [3], corner_z [3];

   logic              rsp_valid_ff;
   logic [2:0]        face_ff;
   logic [5:0]        cx_ff [3], cy_ff [3], cz_ff [3];
   logic              last_ff;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [4:0] v);
      logic [SIZE_W-1:0] s;
      if (v == 5'd0) s = SIZE_W'(1);
      else if (int'(v) > MAX_SIDE) s = SIZE_W'(MAX_SIDE);
      else s = SIZE_W'(v);
      return s;
   endfunction

   function automatic logic in_range(input logic signed [7:0] c,
                                     input logic [SIZE_W-1:0] s);
      return (c >= 8'sd0) && (c < $signed(8'(s)));
   endfunction

   // half-unit corner: 2*coord - size -/+ 1, kept modulo 64
   function automatic logic [5:0] half(input logic [3:0] c, input logic [SIZE_W-1:0] s,
                                       input logic plus);
      logic [5:0] base;
      base = {1'b0, c, 1'b0} - 6'(s);
      return plus ? base + 6'd1 : base - 6'd1;
   endfunction

   assign sx = eff_size(size_x_ff);
   assign sy = eff_size(size_y_ff);
   assign sz = eff_size(size_z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= 5'd16;
         size_y_ff <= 5'd16;
         size_z_ff <= 5'd16;
         edge_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata;
            CSR_SIZE_Y: size_y_ff <= csr_wdata;
            CSR_SIZE_Z: size_z_ff <= csr_wdata;
            CSR_EDGE:   edge_ff   <= csr_wdata[0];
            default:    edge_ff   <= edge_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_op;
         x_ff    <= req_pos_x;
         y_ff    <= req_pos_y;
         z_ff    <= req_pos_z;
         type_ff <= req_voxel_type;
      end
   end

   // neighbour (or the voxel itself) addressed by the current read step
   assign off        = step_offset(cmd.rd_step);
   assign nx         = $signed({4'd0, x_ff}) + 8'(off.dx);
   assign ny         = $signed({4'd0, y_ff}) + 8'(off.dy);
   assign nz         = $signed({4'd0, z_ff}) + 8'(off.dz);
   assign nb_in_grid = in_range(nx, sx) && in_range(ny, sy) && in_range(nz, sz);
   assign nb_addr    = ADDR_W'(nx) + ADDR_W'(ny) * ADDR_W'(MAX_SIDE)
                     + ADDR_W'(nz) * ADDR_W'(MAX_SIDE * MAX_SIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_en && (clr_addr_ff != ADDR_W'(DEPTH - 1))) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign ram_wr_en   = cmd.clear_en || cmd.write;
   assign ram_wr_addr = cmd.clear_en ? clr_addr_ff : nb_addr;
   assign ram_wr_data = cmd.clear_en ? EMPTY_CODE : type_ff;

   vvfm_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en && nb_in_grid),
      .rd_addr (nb_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_step_ff    <= cmd.rd_step;
      rd_in_grid_ff <= nb_in_grid;
   end

   // outside the grid the edge setting decides
   assign rd_empty = rd_in_grid_ff ? (rd_data == EMPTY_CODE) : edge_ff;

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         case (rd_step_ff)
            STEP_CENTRE: centre_empty_ff <= rd_empty;
            3'd1:        mask_ff[0]      <= rd_empty;
            3'd2:        mask_ff[1]      <= rd_empty;
            3'd3:        mask_ff[2]      <= rd_empty;
            3'd4:        mask_ff[3]      <= rd_empty;
            3'd5:        mask_ff[4]      <= rd_empty;
            3'd6:        mask_ff[5]      <= rd_empty;
            default:     mask_ff         <= mask_ff;
         endcase
      end
   end

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         mx[p] = half(x_ff, sx, p[0]);
         my[p] = half(y_ff, sy, p[0]);
         mz[p] = half(z_ff, sz, p[0]);
      end
   end

   always_comb begin
      logic [2:0] code;
      for (int k = 0; k < 3; k++) begin
         code        = TRI_CORNERS[cmd.face][3'(k) + (cmd.tri_sel ? 3'd3 : 3'd0)];
         corner_x[k] = mx[code[0]];
         corner_y[k] = my[code[1]];
         corner_z[k] = mz[code[2]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         face_ff <= cmd.face;
         last_ff <= cmd.last;
         cx_ff   <= corner_x;
         cy_ff   <= corner_y;
         cz_ff   <= corner_z;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.face  = face_ff;
   assign rsp_ch.ax    = $signed(cx_ff[0]);
   assign rsp_ch.ay    = $signed(cy_ff[0]);
   assign rsp_ch.az    = $signed(cz_ff[0]);
   assign rsp_ch.bx    = $signed(cx_ff[1]);
   assign rsp_ch.by    = $signed(cy_ff[1]);
   assign rsp_ch.bz    = $signed(cz_ff[1]);
   assign rsp_ch.cx    = $signed(cx_ff[2]);
   assign rsp_ch.cy    = $signed(cy_ff[2]);
   assign rsp_ch.cz    = $signed(cz_ff[2]);
   assign rsp_ch.last  = last_ff;

   assign status.in_grid      = in_range($signed({4'd0, x_ff}), sx)
                              && in_range($signed({4'd0, y_ff}), sy)
                              && in_range($signed({4'd0, z_ff}), sz);
   assign status.is_query     = (op_ff == OP_QUERY);
   assign status.centre_empty = centre_empty_ff;
   assign status.face_mask    = mask_ff;
   assign status.out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign status.clear_done   = (clr_addr_ff == ADDR_W'(DEPTH - 1));
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the voxel visible face mesher: directed table, then random phases.
module tb;
   import vvfm_pkg::*;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum logic [2:0] {
      FACE_FRONT, FACE_LEFT, FACE_RIGHT, FACE_BACK, FACE_TOP, FACE_BOTTOM
   } face_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              op;
      logic [3:0]        x;
      logic [3:0]        y;
      logic [3:0]        z;
      logic [7:0]        vtype;
      logic [1:0]        csr_idx;
      logic [4:0]        csr_val;
      logic signed [4:0] tris;
   } plan_row_type;

   typedef struct {
      logic [2:0]        face;
      logic signed [5:0] corner [9];
      logic              last;
   } tri_type;

   localparam int SIDE           = 16;
   localparam int PLAN_ROWS      = 27;
   localparam int NUM_PHASES     = 6;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int PRESSURE_PHASE = 4;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 40;

   localparam logic signed [4:0] NO_COUNT = -5'sd1;

   // corner code: bit 0 = +x half, bit 1 = +y half, bit 2 = +z half
   localparam int CORNER_CODE [6][6] = '{
      '{0, 2, 1, 2, 3, 1},
      '{4, 6, 0, 6, 2, 0},
      '{1, 3, 5, 3, 7, 5},
      '{5, 7, 4, 7, 6, 4},
      '{4, 0, 5, 0, 1, 5},
      '{2, 6, 3, 6, 7, 3}
   };
   localparam int NB_DX [6] = '{0, -1, 1, 0, 0, 0};
   localparam int NB_DY [6] = '{0, 0, 0, 0, -1, 1};
   localparam int NB_DZ [6] = '{-1, 0, 0, 1, 0, 0};

   localparam logic [4:0] PH_SX   [NUM_PHASES] = '{5'd4, 5'd3, 5'd16, 5'd1, 5'd31, 5'd2};
   localparam logic [4:0] PH_SY   [NUM_PHASES] = '{5'd4, 5'd2, 5'd16, 5'd1, 5'd0, 5'd2};
   localparam logic [4:0] PH_SZ   [NUM_PHASES] = '{5'd4, 5'd5, 5'd16, 5'd1, 5'd17, 5'd2};
   localparam logic [4:0] PH_EDGE [NUM_PHASES] = '{5'd1, 5'd0, 5'd30, 5'd31, 5'd1, 5'd0};
   localparam int PH_SEND_IDLE [NUM_PHASES] = '{8, 8, 64, 64, 0, 0};
   localparam int PH_RECV_IDLE [NUM_PHASES] = '{64, 64, 8, 8, 0, 0};

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // default grid, open edges
      '{ROW_ITEM, OP_QUERY, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_WRITE, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_QUERY, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  5'sd12},
      '{ROW_ITEM, OP_WRITE, 4'd15, 4'd15, 4'd15, 8'h7F, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_QUERY, 4'd15, 4'd15, 4'd15, 8'h00, CSR_SIZE_X, 5'd0,  5'sd12},
      // negative type other than empty counts as filled
      '{ROW_ITEM, OP_WRITE, 4'd1,  4'd0,  4'd0,  8'h80, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_QUERY, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  NO_COUNT},
      '{ROW_ITEM, OP_QUERY, 4'd1,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  NO_COUNT},
      '{ROW_ITEM, OP_WRITE, 4'd1,  4'd0,  4'd0,  8'hFF, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_QUERY, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  5'sd12},
      '{ROW_ITEM, OP_QUERY, 4'd1,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  5'sd0},
      // fully enclosed voxel
      '{ROW_ITEM, OP_WRITE, 4'd5,  4'd5,  4'd5,  8'h55, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_WRITE, 4'd5,  4'd5,  4'd4,  8'h2A, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_WRITE, 4'd4,  4'd5,  4'd5,  8'hAA, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_WRITE, 4'd6,  4'd5,  4'd5,  8'h01, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_WRITE, 4'd5,  4'd5,  4'd6,  8'hFE, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_WRITE, 4'd5,  4'd4,  4'd5,  8'h40, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_WRITE, 4'd5,  4'd6,  4'd5,  8'hC3, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_QUERY, 4'd5,  4'd5,  4'd5,  8'h00, CSR_SIZE_X, 5'd0,  5'sd0},
      // sizes out of range clamp, closed edges
      '{ROW_CSR,  OP_WRITE, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  NO_COUNT},
      '{ROW_CSR,  OP_WRITE, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_Y, 5'd31, NO_COUNT},
      '{ROW_CSR,  OP_WRITE, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_Z, 5'd2,  NO_COUNT},
      '{ROW_CSR,  OP_WRITE, 4'd0,  4'd0,  4'd0,  8'h00, CSR_EDGE,   5'd0,  NO_COUNT},
      '{ROW_ITEM, OP_WRITE, 4'd1,  4'd0,  4'd0,  8'h09, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_QUERY, 4'd1,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  5'sd0},
      '{ROW_ITEM, OP_QUERY, 4'd0,  4'd0,  4'd0,  8'h00, CSR_SIZE_X, 5'd0,  NO_COUNT},
      '{ROW_ITEM, OP_QUERY, 4'd0,  4'd0,  4'd1,  8'h00, CSR_SIZE_X, 5'd0,  5'sd0}
   };

   localparam string CORNER_NAME [9] = '{"ax", "ay", "az", "bx", "by", "bz", "cx", "cy", "cz"};

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [4:0] csr_wdata;

   vvfm_req_if req_ch ();
   vvfm_rsp_if rsp_ch ();

   voxel_visible_face_mesher dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // predictor state
   logic [7:0] voxel_mem [SIDE*SIDE*SIDE];
   logic [4:0] size_x_reg, size_y_reg, size_z_reg;
   logic       edge_empty_reg;
   tri_type    tri_q [$];

   int err_count     = 0;
   int items_sent    = 0;
   int queries_sent  = 0;
   int tris_checked  = 0;
   int settings_used = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request  = 1'b0;
   int hold_left     = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int eff_side(logic [4:0] v);
      if (v < 1) return 1;
      if (v > SIDE) return SIDE;
      return int'(v);
   endfunction

   function automatic int vox_index(int x, int y, int z);
      return x + y * SIDE + z * SIDE * SIDE;
   endfunction

   function automatic logic signed [5:0] half_unit(int c, int side, bit plus);
      int v;
      v = 2 * c - side + (plus ? 1 : -1);
      return v[5:0];
   endfunction

   // Apply one item to the store and queue the triangles it yields.
   function automatic int predict_item(logic op, logic [3:0] px, logic [3:0] py,
                                       logic [3:0] pz, logic [7:0] vtype);
      int      sx, sy, sz, x, y, z, nx, ny, nz, code;
      bit      open_face;
      tri_type t;
      tri_type fresh [$];
      sx = eff_side(size_x_reg);
      sy = eff_side(size_y_reg);
      sz = eff_side(size_z_reg);
      x = px;
      y = py;
      z = pz;
      if (x >= sx || y >= sy || z >= sz) return 0;
      if (op == OP_WRITE) begin
         voxel_mem[vox_index(x, y, z)] = vtype;
         return 0;
      end
      if (voxel_mem[vox_index(x, y, z)] == EMPTY_CODE) return 0;
      for (int f = FACE_FRONT; f <= FACE_BOTTOM; f++) begin
         nx = x + NB_DX[f];
         ny = y + NB_DY[f];
         nz = z + NB_DZ[f];
         if (nx >= 0 && nx < sx && ny >= 0 && ny < sy && nz >= 0 && nz < sz)
            open_face = (voxel_mem[vox_index(nx, ny, nz)] == EMPTY_CODE);
         else
            open_face = edge_empty_reg;
         if (!open_face) continue;
         for (int tr = 0; tr < 2; tr++) begin
            t.face = 3'(f);
            for (int k = 0; k < 3; k++) begin
               code = CORNER_CODE[f][tr * 3 + k];
               t.corner[k * 3]     = half_unit(x, sx, (code & 1) != 0);
               t.corner[k * 3 + 1] = half_unit(y, sy, (code & 2) != 0);
               t.corner[k * 3 + 2] = half_unit(z, sz, (code & 4) != 0);
            end
            t.last = 1'b0;
            fresh.push_back(t);
         end
      end
      if (fresh.size() > 0) fresh[$].last = 1'b1;
      foreach (fresh[i]) tri_q.push_back(fresh[i]);
      return fresh.size();
   endfunction

   // Mostly a small window at the low or high end of the axis, sometimes anywhere.
   function automatic logic [3:0] pick_coord(int side);
      int r, w, base;
      r = $urandom_range(99);
      w = (side < 4) ? side : 4;
      if (r < 15) return 4'($urandom_range(15));
      base = (r < 57) ? 0 : side - w;
      return 4'(base + $urandom_range(w - 1));
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d actual %0d", name, want, got);
         err_count++;
      end
   endtask

   task automatic send_item(input logic op, input logic [3:0] px, input logic [3:0] py,
                            input logic [3:0] pz, input logic [7:0] vtype,
                            output int n_tris);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.op         = op;
      req_ch.pos_x      = px;
      req_ch.pos_y      = py;
      req_ch.pos_z      = pz;
      req_ch.voxel_type = vtype;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_tris = predict_item(op, px, py, pz, vtype);
      items_sent++;
      if (op == OP_QUERY) queries_sent++;
   endtask

   // Drop valid, wait for every triangle, then let a query that yields nothing finish.
   task automatic wait_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (tri_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [4:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_SIZE_X: size_x_reg = val;
         CSR_SIZE_Y: size_y_reg = val;
         CSR_SIZE_Z: size_z_reg = val;
         CSR_EDGE:   edge_empty_reg = val[0];
         default:    ;
      endcase
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_tri
      tri_type           want;
      logic signed [5:0] got [9];
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.ax, rsp_ch.ay, rsp_ch.az, rsp_ch.bx, rsp_ch.by, rsp_ch.bz,
                 rsp_ch.cx, rsp_ch.cy, rsp_ch.cz};
         if (tri_q.size() == 0) begin
            $error("unexpected triangle: face %0d", rsp_ch.face);
            err_count++;
         end else begin
            want = tri_q.pop_front();
            tris_checked++;
            check_field("face", want.face, rsp_ch.face);
            for (int k = 0; k < 9; k++) check_field(CORNER_NAME[k], want.corner[k], got[k]);
            check_field("last", want.last, rsp_ch.last);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int         n_tris;
      logic       op;
      logic [3:0] px, py, pz;
      logic [7:0] vt;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_SIZE_X;
      csr_wdata         = 5'd0;
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_WRITE;
      req_ch.pos_x      = 4'd0;
      req_ch.pos_y      = 4'd0;
      req_ch.pos_z      = 4'd0;
      req_ch.voxel_type = 8'sd0;
      foreach (voxel_mem[i]) voxel_mem[i] = EMPTY_CODE;
      size_x_reg     = 5'd16;
      size_y_reg     = 5'd16;
      size_z_reg     = 5'd16;
      edge_empty_reg = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = PH_SEND_IDLE[0];
      recv_idle_pct = PH_RECV_IDLE[0];
      settings_used = 1;
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].kind == ROW_CSR) begin
            if (r == 0 || PLAN[r - 1].kind != ROW_CSR) begin
               wait_drained();
               settings_used++;
            end
            write_csr(PLAN[r].csr_idx, PLAN[r].csr_val);
         end else begin
            send_item(PLAN[r].op, PLAN[r].x, PLAN[r].y, PLAN[r].z, PLAN[r].vtype, n_tris);
            if (PLAN[r].tris != NO_COUNT && n_tris != PLAN[r].tris) begin
               $error("row %0d triangle count: expected %0d actual %0d",
                      r, PLAN[r].tris, n_tris);
               err_count++;
            end
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         send_idle_pct = PH_SEND_IDLE[p];
         recv_idle_pct = PH_RECV_IDLE[p];
         write_csr(CSR_SIZE_X, PH_SX[p]);
         write_csr(CSR_SIZE_Y, PH_SY[p]);
         write_csr(CSR_SIZE_Z, PH_SZ[p]);
         write_csr(CSR_EDGE, PH_EDGE[p]);
         settings_used++;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // fill the window first, then mostly query it
            if (i < ITEMS_PER_PHASE * 3 / 10)
               op = ($urandom_range(99) < 20) ? OP_QUERY : OP_WRITE;
            else
               op = ($urandom_range(99) < 60) ? OP_QUERY : OP_WRITE;
            px = pick_coord(eff_side(size_x_reg));
            py = pick_coord(eff_side(size_y_reg));
            pz = pick_coord(eff_side(size_z_reg));
            vt = ($urandom_range(99) < 35) ? EMPTY_CODE : 8'($urandom_range(255));
            if (p == PRESSURE_PHASE && i == ITEMS_PER_PHASE / 3) hold_request = 1'b1;
            send_item(op, px, py, pz, vt, n_tris);
         end
      end

      wait_drained();
      if (tri_q.size() != 0) begin
         $error("%0d expected triangles never arrived", tri_q.size());
         err_count++;
      end
      $display("Sent %0d items (%0d queries) over %0d grid settings; checked %0d triangles.",
               items_sent, queries_sent, settings_used, tris_checked);
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
